FILE: src/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// Shared widths, types and helpers for the plane reflection / projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

	// coordinate width and fraction bits (Q16.16)
	localparam int CW   = 32;
	localparam int FB   = 16;
	// full product width and working width for sums
	localparam int PW   = 2 * CW;
	localparam int SW   = PW + 4;
	// one quotient bit per divider stage
	localparam int NDIV = PW;
	localparam int IDXW = 3;

	typedef enum logic [IDXW-1:0] {
		REG_NX     = 3'd0,
		REG_NY     = 3'd1,
		REG_NZ     = 3'd2,
		REG_DIST   = 3'd3,
		REG_SCALEX = 3'd4,
		REG_SCALEY = 3'd5,
		REG_OFFX   = 3'd6,
		REG_OFFY   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic signed [CW-1:0] nz;
		logic signed [CW-1:0] plane_d;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
	} cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 last;
	} vtx_t;

	// reflected point, t and marker travelling alongside the dividers
	typedef struct packed {
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
		logic signed [CW-1:0] rz;
		logic signed [CW-1:0] t;
		logic                 last;
	} side_t;

	localparam logic signed [CW-1:0] CW_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CW_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] FX_ONE = CW'(1) << FB;

	// saturate a wide signed value to CW bits
	function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] mx;
		logic signed [SW-1:0] mn;
		mx = SW'(CW_MAX);
		mn = SW'(CW_MIN);
		if (v > mx)
			return CW_MAX;
		else if (v < mn)
			return CW_MIN;
		else
			return v[CW-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/plane_reflect_perspective_project.sv
// ----------------------------------------------------------------------------
// plane_reflect_perspective_project
// Reflects a vertex across a plane and projects it in perspective.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries one vertex per request; output
//    channel out_valid/out_stall returns one result per vertex, in order.
//  - Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//    always high. Write only while the pipeline is empty.
//  - Throughput: one vertex per cycle while out_stall is not holding the pipeline.
//  - A vertex passes the dot-product, reflection, divider and output registers;
//    the divider resolves one quotient bit per stage over 64 stages.
//  - The whole pipeline advances together; while a result waits under
//    out_stall the pipeline holds and in_stall is raised, nothing is lost.
//  - Reset clears all valid bits and loads the registers with their defaults
//    (normal 0,0,1.0, distance 0, scales 1.0, offsets 0).
// ----------------------------------------------------------------------------
`default_nettype none

module plane_reflect_perspective_project import prp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire logic signed [CW-1:0]   vert_x,
	input  wire logic signed [CW-1:0]   vert_y,
	input  wire logic signed [CW-1:0]   vert_z,
	input  wire logic                   last_in,
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      logic signed [CW-1:0]   refl_x,
	output      logic signed [CW-1:0]   refl_y,
	output      logic signed [CW-1:0]   refl_z,
	output      logic signed [CW-1:0]   refl_scale,
	output      logic signed [CW-1:0]   screen_x,
	output      logic signed [CW-1:0]   screen_y,
	output      logic                   depth_zero,
	output      logic                   last_out,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [IDXW-1:0]        cfg_index,
	input  wire logic signed [CW-1:0]   cfg_data
);

	cfg_t                 cfg_q;
	logic                 en;
	vtx_t                 vtx_in;
	logic                 v_s2, v_s5;
	vtx_t                 vtx_s2;
	logic signed [CW-1:0] t_s2;
	side_t                side_s5;
	logic signed [PW-1:0] numx_s5, numy_s5;
	logic signed [CW-1:0] scx, scy;
	logic                 dv_s   [0:NDIV];
	side_t                side_s [0:NDIV];

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			cfg_q.nz <= FX_ONE;
			cfg_q.sx <= FX_ONE;
			cfg_q.sy <= FX_ONE;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NX:     cfg_q.nx      <= cfg_data;
				REG_NY:     cfg_q.ny      <= cfg_data;
				REG_NZ:     cfg_q.nz      <= cfg_data;
				REG_DIST:   cfg_q.plane_d <= cfg_data;
				REG_SCALEX: cfg_q.sx      <= cfg_data;
				REG_SCALEY: cfg_q.sy      <= cfg_data;
				REG_OFFX:   cfg_q.ox      <= cfg_data;
				REG_OFFY:   cfg_q.oy      <= cfg_data;
				default:    cfg_q         <= cfg_q;
			endcase
		end
	end

	assign vtx_in = '{x: vert_x, y: vert_y, z: vert_z, last: last_in};

	// plane distance and t
	prp_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid && en),
		.vtx_in (vtx_in),
		.cfg    (cfg_q),
		.v_s2   (v_s2),
		.vtx_s2 (vtx_s2),
		.t_s2   (t_s2)
	);

	// reflection and numerators
	prp_refl u_refl (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_s2),
		.vtx_in  (vtx_s2),
		.t_in    (t_s2),
		.cfg     (cfg_q),
		.v_s5    (v_s5),
		.side_s5 (side_s5),
		.numx_s5 (numx_s5),
		.numy_s5 (numy_s5)
	);

	// perspective divides
	prp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s5),
		.den (side_s5.rz),
		.off (cfg_q.ox),
		.res (scx)
	);

	prp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s5),
		.den (side_s5.rz),
		.off (cfg_q.oy),
		.res (scy)
	);

	// valid bits alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NDIV; i++)
				dv_s[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s5;
			for (int i = 0; i < NDIV; i++)
				dv_s[i+1] <= dv_s[i];
			out_valid <= dv_s[NDIV];
		end
	end

	// side data alongside the dividers, then output register
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_s5;
			for (int i = 0; i < NDIV; i++)
				side_s[i+1] <= side_s[i];
			refl_x     <= side_s[NDIV].rx;
			refl_y     <= side_s[NDIV].ry;
			refl_z     <= side_s[NDIV].rz;
			refl_scale <= side_s[NDIV].t;
			screen_x   <= scx;
			screen_y   <= scy;
			depth_zero <= (side_s[NDIV].rz == '0);
			last_out   <= side_s[NDIV].last;
		end
	end

endmodule

`default_nettype wire

FILE: src/prp_dot.sv
// ----------------------------------------------------------------------------
// prp_dot
// Two stages: n.p products, then exact sum, floor shift and t = -2(n.p - d).
// ----------------------------------------------------------------------------
`default_nettype none

module prp_dot import prp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 v_in,
	input  wire vtx_t                 vtx_in,
	input  wire cfg_t                 cfg,
	output      logic                 v_s2,
	output      vtx_t                 vtx_s2,
	output      logic signed [CW-1:0] t_s2
);

	logic                 v_s1;
	vtx_t                 vtx_s1;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [SW-1:0] sum, sh, e;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s1 <= vtx_in;
			px_s1  <= vtx_in.x * cfg.nx;
			py_s1  <= vtx_in.y * cfg.ny;
			pz_s1  <= vtx_in.z * cfg.nz;
		end
	end

	// exact sum, one floor shift, subtract d, scale by -2
	always_comb begin
		sum = SW'(px_s1) + SW'(py_s1) + SW'(pz_s1);
		sh  = sum >>> FB;
		e   = sh - SW'(cfg.plane_d);
	end

	// stage 2: saturated t
	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s2 <= vtx_s1;
			t_s2   <= sat_cw(-(e <<< 1));
		end
	end

endmodule

`default_nettype wire

FILE: src/prp_refl.sv
// ----------------------------------------------------------------------------
// prp_refl
// Three stages: t*n products, saturated p + t*n, scale * coordinate products.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_refl import prp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 v_in,
	input  wire vtx_t                 vtx_in,
	input  wire logic signed [CW-1:0] t_in,
	input  wire cfg_t                 cfg,
	output      logic                 v_s5,
	output      side_t                side_s5,
	output      logic signed [PW-1:0] numx_s5,
	output      logic signed [PW-1:0] numy_s5
);

	logic                 v_s3, v_s4;
	vtx_t                 vtx_s3;
	logic signed [CW-1:0] t_s3;
	logic signed [PW-1:0] tnx_s3, tny_s3, tnz_s3;
	side_t                side_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 3: t * n
	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s3 <= vtx_in;
			t_s3   <= t_in;
			tnx_s3 <= t_in * cfg.nx;
			tny_s3 <= t_in * cfg.ny;
			tnz_s3 <= t_in * cfg.nz;
		end
	end

	// stage 4: reflected point, saturated
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.rx   <= sat_cw(SW'(vtx_s3.x) + SW'(tnx_s3 >>> FB));
			side_s4.ry   <= sat_cw(SW'(vtx_s3.y) + SW'(tny_s3 >>> FB));
			side_s4.rz   <= sat_cw(SW'(vtx_s3.z) + SW'(tnz_s3 >>> FB));
			side_s4.t    <= t_s3;
			side_s4.last <= vtx_s3.last;
		end
	end

	// stage 5: projection numerators
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			numx_s5 <= cfg.sx * side_s4.rx;
			numy_s5 <= cfg.sy * side_s4.ry;
		end
	end

endmodule

`default_nettype wire

FILE: src/prp_div.sv
// ----------------------------------------------------------------------------
// prp_div
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero; adds the offset and saturates. Zero divisor gives a signed extreme.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_div import prp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [PW-1:0] num,
	input  wire logic signed [CW-1:0] den,
	input  wire logic signed [CW-1:0] off,
	output      logic signed [CW-1:0] res
);

	logic [PW-1:0]        w_s    [0:NDIV];
	logic [PW-1:0]        q_s    [0:NDIV];
	logic [CW-1:0]        rem_s  [0:NDIV];
	logic [CW-1:0]        dm_s   [0:NDIV];
	logic                 neg_s  [0:NDIV];
	logic                 nneg_s [0:NDIV];
	logic                 zero_s [0:NDIV];
	logic signed [CW-1:0] off_s  [0:NDIV];

	logic [CW:0]          tr     [0:NDIV-1];
	logic                 ge     [0:NDIV-1];
	logic signed [PW:0]   qs;
	logic signed [SW-1:0] sum;

	// entry stage: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			w_s[0]    <= num[PW-1] ? PW'(-num) : num;
			dm_s[0]   <= den[CW-1] ? CW'(-den) : den;
			q_s[0]    <= '0;
			rem_s[0]  <= '0;
			neg_s[0]  <= num[PW-1] ^ den[CW-1];
			nneg_s[0] <= num[PW-1];
			zero_s[0] <= (den == '0);
			off_s[0]  <= off;
		end
	end

	// trial subtraction per stage
	always_comb begin
		for (int i = 0; i < NDIV; i++) begin
			tr[i] = {rem_s[i], w_s[i][PW-1]};
			ge[i] = (tr[i] >= {1'b0, dm_s[i]});
		end
	end

	// iteration stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NDIV; i++) begin
				rem_s[i+1]  <= ge[i] ? CW'(tr[i] - {1'b0, dm_s[i]}) : tr[i][CW-1:0];
				w_s[i+1]    <= w_s[i] << 1;
				q_s[i+1]    <= {q_s[i][PW-2:0], ge[i]};
				dm_s[i+1]   <= dm_s[i];
				neg_s[i+1]  <= neg_s[i];
				nneg_s[i+1] <= nneg_s[i];
				zero_s[i+1] <= zero_s[i];
				off_s[i+1]  <= off_s[i];
			end
		end
	end

	// sign, offset and saturation
	always_comb begin
		qs  = neg_s[NDIV] ? -$signed({1'b0, q_s[NDIV]}) : $signed({1'b0, q_s[NDIV]});
		sum = SW'(qs) + SW'(off_s[NDIV]);
		if (zero_s[NDIV])
			res = nneg_s[NDIV] ? CW_MIN : CW_MAX;
		else
			res = sat_cw(sum);
	end

endmodule

`default_nettype wire
